// ===== design/ffsb_pkg.sv =====
package ffsb_pkg;

  // Device and map geometry.
  localparam int MAX_SECTORS          = 4096;
  localparam int RESERVED_MAP_SECTOR  = 0;
  localparam int RESERVED_ROOT_SECTOR = 1;
  localparam int WORD_W               = 64;
  localparam int MAP_WORDS            = (MAX_SECTORS + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W           = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W            = $clog2(WORD_W);

  // Field widths.
  localparam int SECTOR_W = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_SECTORS);

  // Request and status codes.
  localparam logic ACT_ALLOCATE = 1'b0;
  localparam logic ACT_RELEASE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREE_RELEASE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE        = 2'd3;

  // Word and bit position of the reserved sectors.
  localparam int RSV_MAP_WORD  = RESERVED_MAP_SECTOR / WORD_W;
  localparam int RSV_MAP_BIT   = RESERVED_MAP_SECTOR % WORD_W;
  localparam int RSV_ROOT_WORD = RESERVED_ROOT_SECTOR / WORD_W;
  localparam int RSV_ROOT_BIT  = RESERVED_ROOT_SECTOR % WORD_W;

  // Result of the lowest-free-bit search.
  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] index;
  } find_t;

  // Content of a map word after reset: only the reserved sectors are used.
  function automatic logic [WORD_W-1:0] reset_word(input logic [WORD_IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    w = '0;
    if (RESERVED_MAP_SECTOR < MAX_SECTORS && idx == WORD_IDX_W'(RSV_MAP_WORD)) begin
      w[RSV_MAP_BIT] = 1'b1;
    end
    if (RESERVED_ROOT_SECTOR < MAX_SECTORS && idx == WORD_IDX_W'(RSV_ROOT_WORD)) begin
      w[RSV_ROOT_BIT] = 1'b1;
    end
    return w;
  endfunction

endpackage

// ===== design/ffsb_ram.sv =====
module ffsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ffsb_find.sv =====
module ffsb_find
  import ffsb_pkg::*;
(
  input  logic [WORD_W-1:0] avail,
  output find_t             res
);

  // Lowest set bit of the free mask; the downward sweep leaves the lowest index.
  always_comb begin
    res.found = |avail;
    res.index = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        res.index = BIT_IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/first_fit_sector_bitmap_allocator_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    action, sector
// out      output     out_valid/out_ready  granted_sector, status
// cfg      input      cfg_valid/cfg_ready  sector_count
//
// An allocate reads k map words, where k (0 to 64) is the number of words read
// until a free sector is found or the managed range ends; the single read port of the
// map memory delivers one word per cycle. A release reads only the target word, and
// none when the sector is out of range.
// Synchronous reset restores the map at once through per-word valid bits.
// A result waits in the output register while the next transaction is accepted.
module first_fit_sector_bitmap_allocator_unit
  import ffsb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [SECTOR_W-1:0] sector,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SECTOR_W-1:0] granted_sector,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  sector_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REL,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [COUNT_W-1:0]     count;
  logic [WORD_IDX_W-1:0]  word_idx;
  logic [BIT_IDX_W-1:0]   rel_bit;
  logic [MAP_WORDS-1:0]   word_valid;
  logic [SECTOR_W-1:0]    res_sector;
  logic [STATUS_W-1:0]    res_status;

  logic                   in_fire;
  logic [COUNT_W-1:0]     limit;
  logic [COUNT_W-1:0]     limit_m1;
  logic [WORD_IDX_W-1:0]  last_word;
  logic [BIT_IDX_W-1:0]   tail;
  logic [WORD_W-1:0]      span_mask;
  logic [WORD_W-1:0]      rdata;
  logic [WORD_W-1:0]      cur_word;
  logic [WORD_W-1:0]      rel_mask;
  logic [WORD_W-1:0]      avail;
  find_t                  find;
  logic                   mem_we;
  logic [WORD_W-1:0]      mem_wdata;
  logic [WORD_IDX_W-1:0]  mem_raddr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Managed range, saturated at the map size.
  assign limit     = (count > COUNT_MAX) ? COUNT_MAX : count;
  assign limit_m1  = limit - COUNT_W'(1);
  assign last_word = limit_m1[SECTOR_W-1:BIT_IDX_W];
  assign tail      = limit_m1[BIT_IDX_W-1:0];
  assign span_mask = (word_idx == last_word)
                     ? ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - tail))
                     : {WORD_W{1'b1}};

  // A word never written since reset reads as its reset content.
  assign cur_word = word_valid[word_idx] ? rdata : reset_word(word_idx);
  assign avail    = ~cur_word & span_mask;
  assign rel_mask = WORD_W'(1) << rel_bit;

  ffsb_find u_find (
    .avail (avail),
    .res   (find)
  );

  // Read address: first word on a new allocate, the target word on a release,
  // and the following word while scanning.
  always_comb begin
    case (state)
      ST_IDLE: mem_raddr = (action == ACT_RELEASE) ? sector[SECTOR_W-1:BIT_IDX_W] : '0;
      ST_SCAN: mem_raddr = word_idx + WORD_IDX_W'(1);
      default: mem_raddr = word_idx;
    endcase
  end

  // Write back the modified word when a bit is set or cleared.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = cur_word;
    case (state)
      ST_SCAN: begin
        mem_we    = find.found;
        mem_wdata = cur_word | (WORD_W'(1) << find.index);
      end
      ST_REL: begin
        mem_we    = |(cur_word & rel_mask);
        mem_wdata = cur_word & ~rel_mask;
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = cur_word;
      end
    endcase
  end

  ffsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (word_idx),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Sequencer, result holding and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      word_valid <= '0;
      count      <= COUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count <= sector_count;
      end
      if (mem_we) begin
        word_valid[word_idx] <= 1'b1;
      end
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_sector <= '0;
            rel_bit    <= sector[BIT_IDX_W-1:0];
            if (action == ACT_RELEASE) begin
              word_idx <= sector[SECTOR_W-1:BIT_IDX_W];
              if ({1'b0, sector} >= limit) begin
                res_status <= STATUS_RANGE;
                state      <= ST_DONE;
              end else begin
                state <= ST_REL;
              end
            end else begin
              word_idx <= '0;
              if (limit == '0) begin
                res_status <= STATUS_FULL;
                state      <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (find.found) begin
            res_sector <= SECTOR_W'({word_idx, find.index});
            res_status <= STATUS_OK;
            state      <= ST_DONE;
          end else if (word_idx == last_word) begin
            res_status <= STATUS_FULL;
            state      <= ST_DONE;
          end else begin
            word_idx <= word_idx + WORD_IDX_W'(1);
          end
        end
        ST_REL: begin
          res_status <= (|(cur_word & rel_mask)) ? STATUS_OK : STATUS_FREE_RELEASE;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            granted_sector <= res_sector;
            status         <= res_status;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The map is only written during a scan or a release.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !mem_we)
    else $error("map written outside scan or release");

  // Every map write ends the transaction's work.
  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == ST_DONE))
    else $error("map write not followed by result");

  // No new transaction is accepted right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second transaction accepted while busy");

  // Only a successful allocate hands out a nonzero sector.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (granted_sector == '0))
    else $error("nonzero sector on failed transaction");
`endif

endmodule
